[rtl/core/motor_drive_safety_ramp_top_defines.svh]
// Assertion macros shared by the motor drive safety ramp RTL.
`ifndef MOTOR_DRIVE_SAFETY_RAMP_TOP_DEFINES_SVH
`define MOTOR_DRIVE_SAFETY_RAMP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MDSR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mdsr assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MDSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mdsr assertion failed");

`endif

[rtl/core/mdsr_pkg.sv]
// Shared types, codes and constants of the motor drive safety ramp.
`default_nettype none
package mdsr_pkg;

  localparam int AGE_BITS      = 16;
  localparam int DISTANCE_BITS = 10;
  localparam int SAFE_BITS     = 10;
  localparam int TIMEOUT_BITS  = 16;
  localparam int DUTY_BITS     = 8;
  localparam int CMD_BITS      = 8;
  localparam int PAT_BITS      = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;

  // Stream payload layout.
  localparam int IN_FIELD_BITS  = 2 * CMD_BITS + 3 * DISTANCE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = DUTY_BITS + PAT_BITS + 3 + 3;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

  // ASCII command bytes.
  localparam logic [CMD_BITS-1:0] CMD_COAST = 8'h53;
  localparam logic [CMD_BITS-1:0] CMD_BRAKE = 8'h58;
  localparam logic [CMD_BITS-1:0] CMD_FWD   = 8'h46;
  localparam logic [CMD_BITS-1:0] CMD_BACK  = 8'h42;
  localparam logic [CMD_BITS-1:0] CMD_LEFT  = 8'h4C;
  localparam logic [CMD_BITS-1:0] CMD_RIGHT = 8'h52;

  // Bridge pin patterns, bit 0 is IN1.
  localparam logic [PAT_BITS-1:0] PAT_FWD   = 4'h5;
  localparam logic [PAT_BITS-1:0] PAT_BACK  = 4'hA;
  localparam logic [PAT_BITS-1:0] PAT_LEFT  = 4'h6;
  localparam logic [PAT_BITS-1:0] PAT_RIGHT = 4'h9;
  localparam logic [PAT_BITS-1:0] PAT_COAST = 4'h0;
  localparam logic [PAT_BITS-1:0] PAT_BRAKE = 4'hF;

  // Register reset values.
  localparam logic [SAFE_BITS-1:0]    RST_GUARD_CM   = 10'd25;
  localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT    = 16'd500;
  localparam logic [DUTY_BITS-1:0]    RST_SLEW_STEP  = 8'd15;
  localparam logic [DUTY_BITS-1:0]    RST_TURN_CAP   = 8'd150;
  localparam logic [DUTY_BITS-1:0]    RST_BRAKE_DUTY = 8'd255;

  typedef enum logic [1:0] {
    KIND_PACKET  = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_CONTROL = 2'd2
  } kind_e;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_GUARD_CM   = 3'd0,
    CFG_TIMEOUT    = 3'd1,
    CFG_SLEW_STEP  = 3'd2,
    CFG_TURN_CAP   = 3'd3,
    CFG_BRAKE_DUTY = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_FWD   = 3'd0,
    MODE_BACK  = 3'd1,
    MODE_LEFT  = 3'd2,
    MODE_RIGHT = 3'd3,
    MODE_COAST = 3'd4,
    MODE_BRAKE = 3'd5,
    MODE_HELD  = 3'd6
  } mode_e;

  typedef struct packed {
    logic [SAFE_BITS-1:0]    guard_cm;
    logic [TIMEOUT_BITS-1:0] age_limit;
    logic [DUTY_BITS-1:0]    slew_step;
    logic [DUTY_BITS-1:0]    turn_cap;
    logic [DUTY_BITS-1:0]    brake_duty;
  } cfg_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]  latched_command;
    logic [DUTY_BITS-1:0] latched_speed;
    logic [AGE_BITS-1:0]  packet_age;
    logic [DUTY_BITS-1:0] motor_duty;
    logic [PAT_BITS-1:0]  held_pattern;
  } state_t;

  typedef struct packed {
    kind_e                    kind;
    logic [CMD_BITS-1:0]      command;
    logic [DUTY_BITS-1:0]     requested_speed;
    logic [DISTANCE_BITS-1:0] left_distance;
    logic [DISTANCE_BITS-1:0] right_distance;
    logic [DISTANCE_BITS-1:0] rear_distance;
  } item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic [PAT_BITS-1:0]  bridge_pattern;
    mode_e                drive_mode;
    logic                 signal_lost;
    logic                 front_blocked;
    logic                 rear_blocked;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/mdsr_ctrl.sv]
// Decision logic: state update and result for one registered input item.
`default_nettype none
module mdsr_ctrl (
  input  mdsr_pkg::item_t   item_i,
  input  mdsr_pkg::state_t  state_i,
  input  mdsr_pkg::cfg_t    cfg_i,
  output mdsr_pkg::state_t  state_o,
  output mdsr_pkg::result_t result_o,
  output logic              has_result_o
);
  import mdsr_pkg::*;

  localparam int DCMP_BITS = (DISTANCE_BITS > SAFE_BITS) ? DISTANCE_BITS : SAFE_BITS;
  localparam int ACMP_BITS = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;

  // A distance of zero means no reading and never blocks.
  function automatic logic blocked(input logic [DISTANCE_BITS-1:0] reading,
                                   input logic [SAFE_BITS-1:0] safe);
    return (reading != '0) && (DCMP_BITS'(reading) <= DCMP_BITS'(safe));
  endfunction

  logic                 front, rear, lost;
  logic [CMD_BITS-1:0]  cmd;
  logic [DUTY_BITS-1:0] target;
  logic [DUTY_BITS-1:0] ramped;
  logic [DUTY_BITS:0]   up_sum;
  logic [DUTY_BITS-1:0] down_diff;
  logic [DUTY_BITS-1:0] new_duty;
  logic [PAT_BITS-1:0]  pattern;
  mode_e                mode;

  assign front = blocked(item_i.left_distance, cfg_i.guard_cm) ||
                 blocked(item_i.right_distance, cfg_i.guard_cm);
  assign rear  = blocked(item_i.rear_distance, cfg_i.guard_cm);
  assign lost  = ACMP_BITS'(state_i.packet_age) > ACMP_BITS'(cfg_i.age_limit);

  // Safety overrides in priority order.
  always_comb begin
    cmd    = state_i.latched_command;
    target = state_i.latched_speed;
    if (lost) begin
      cmd    = CMD_COAST;
      target = '0;
    end else if ((cmd == CMD_FWD && front) || (cmd == CMD_BACK && rear)) begin
      cmd    = CMD_BRAKE;
      target = cfg_i.brake_duty;
    end else if (cmd == CMD_LEFT || cmd == CMD_RIGHT) begin
      if (target > cfg_i.turn_cap) begin
        target = cfg_i.turn_cap;
      end
    end
  end

  // Slew the duty toward the target by at most one step.
  assign up_sum    = {1'b0, state_i.motor_duty} + {1'b0, cfg_i.slew_step};
  assign down_diff = state_i.motor_duty - target;
  always_comb begin
    if (state_i.motor_duty < target) begin
      ramped = (up_sum > {1'b0, target}) ? target : up_sum[DUTY_BITS-1:0];
    end else if (state_i.motor_duty > target) begin
      ramped = (down_diff <= cfg_i.slew_step) ? target
                                              : state_i.motor_duty - cfg_i.slew_step;
    end else begin
      ramped = state_i.motor_duty;
    end
  end

  assign new_duty = (cmd == CMD_COAST || cmd == CMD_BRAKE) ? target : ramped;

  // Bridge pattern and mode; an unknown command keeps the last pattern.
  always_comb begin
    case (cmd)
      CMD_FWD:   begin pattern = PAT_FWD;   mode = MODE_FWD;   end
      CMD_BACK:  begin pattern = PAT_BACK;  mode = MODE_BACK;  end
      CMD_LEFT:  begin pattern = PAT_LEFT;  mode = MODE_LEFT;  end
      CMD_RIGHT: begin pattern = PAT_RIGHT; mode = MODE_RIGHT; end
      CMD_COAST: begin pattern = PAT_COAST; mode = MODE_COAST; end
      CMD_BRAKE: begin pattern = PAT_BRAKE; mode = MODE_BRAKE; end
      default:   begin pattern = state_i.held_pattern; mode = MODE_HELD; end
    endcase
  end

  // Next state per item kind; the unused kind leaves everything alone.
  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    case (item_i.kind)
      KIND_PACKET: begin
        state_o.latched_command = item_i.command;
        state_o.latched_speed   = item_i.requested_speed;
        state_o.packet_age      = '0;
      end
      KIND_TICK: begin
        if (state_i.packet_age != '1) begin
          state_o.packet_age = state_i.packet_age + AGE_BITS'(1);
        end
      end
      KIND_CONTROL: begin
        state_o.motor_duty   = new_duty;
        state_o.held_pattern = pattern;
        has_result_o         = 1'b1;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign result_o.duty           = new_duty;
  assign result_o.bridge_pattern = pattern;
  assign result_o.drive_mode     = mode;
  assign result_o.signal_lost    = lost;
  assign result_o.front_blocked  = front;
  assign result_o.rear_blocked   = rear;

endmodule
`default_nettype wire

[rtl/core/motor_drive_safety_ramp_top.sv]
// Top level of the motor drive safety ramp: stream ports, registers and state.
// A control update is held in the input register; its result is then held in the result register.
// Throughput: one item per cycle unless a result waits on a stalled result stream; the
// decision logic between the input register and the result register is combinational.
// Reset: asynchronous, active low; registers return to 25, 500, 15, 150, 255, the
// latched command to S, and speed, age, duty and pattern to zero.
`default_nettype none
`include "motor_drive_safety_ramp_top_defines.svh"
module motor_drive_safety_ramp_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream.
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata fields from bit 0: command, requested_speed, left_distance,
  // right_distance, rear_distance, zero padding.
  input  logic [mdsr_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata_i,
  // tuser fields from bit 0: kind.
  input  logic [1:0]                           s_axis_tuser_i,
  // Result stream.
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata fields from bit 0: duty, bridge_pattern, drive_mode, signal_lost,
  // front_blocked, rear_blocked, zero padding.
  output logic [mdsr_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata_o,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [mdsr_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  logic [mdsr_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i
);
  import mdsr_pkg::*;

  localparam int CMD_LO   = 0;
  localparam int SPD_LO   = CMD_LO + CMD_BITS;
  localparam int LEFT_LO  = SPD_LO + DUTY_BITS;
  localparam int RIGHT_LO = LEFT_LO + DISTANCE_BITS;
  localparam int REAR_LO  = RIGHT_LO + DISTANCE_BITS;

  item_t   item_in;
  item_t   item_q;
  logic    in_valid_q;
  state_t  state_q, state_d;
  cfg_t    cfg_q;
  result_t result_d, result_q;
  logic    has_result;
  logic    out_valid_q;
  logic    fire;

  // Unpack the incoming transfer.
  assign item_in.kind            = kind_e'(s_axis_tuser_i);
  assign item_in.command         = s_axis_tdata_i[CMD_LO +: CMD_BITS];
  assign item_in.requested_speed = s_axis_tdata_i[SPD_LO +: DUTY_BITS];
  assign item_in.left_distance   = s_axis_tdata_i[LEFT_LO +: DISTANCE_BITS];
  assign item_in.right_distance  = s_axis_tdata_i[RIGHT_LO +: DISTANCE_BITS];
  assign item_in.rear_distance   = s_axis_tdata_i[REAR_LO +: DISTANCE_BITS];

  // The held item retires unless it has a result with nowhere to go.
  assign fire            = in_valid_q && (!has_result || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  mdsr_ctrl u_ctrl (
    .item_i      (item_q),
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .state_o     (state_d),
    .result_o    (result_d),
    .has_result_o(has_result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q <= item_in;
    end
  end

  // Drive state, updated as each item retires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.latched_command <= CMD_COAST;
      state_q.latched_speed   <= '0;
      state_q.packet_age      <= '0;
      state_q.motor_duty      <= '0;
      state_q.held_pattern    <= PAT_COAST;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Configuration registers; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_cm   <= RST_GUARD_CM;
      cfg_q.age_limit  <= RST_TIMEOUT;
      cfg_q.slew_step  <= RST_SLEW_STEP;
      cfg_q.turn_cap   <= RST_TURN_CAP;
      cfg_q.brake_duty <= RST_BRAKE_DUTY;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_GUARD_CM:   cfg_q.guard_cm   <= cfg_wdata_i[SAFE_BITS-1:0];
        CFG_TIMEOUT:    cfg_q.age_limit  <= cfg_wdata_i[TIMEOUT_BITS-1:0];
        CFG_SLEW_STEP:  cfg_q.slew_step  <= cfg_wdata_i[DUTY_BITS-1:0];
        CFG_TURN_CAP:   cfg_q.turn_cap   <= cfg_wdata_i[DUTY_BITS-1:0];
        CFG_BRAKE_DUTY: cfg_q.brake_duty <= cfg_wdata_i[DUTY_BITS-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_BITS{1'b0}}, result_q.rear_blocked,
                            result_q.front_blocked, result_q.signal_lost,
                            result_q.drive_mode, result_q.bridge_pattern, result_q.duty};

  // A stale packet always coasts at duty zero.
  `MDSR_ASSERT_IMPL(a_lost_coasts, out_valid_q && result_q.signal_lost,
                    result_q.drive_mode == MODE_COAST && result_q.duty == '0)
  // Brake mode drives every bridge input high.
  `MDSR_ASSERT_IMPL(a_brake_pattern, out_valid_q && result_q.drive_mode == MODE_BRAKE,
                    result_q.bridge_pattern == PAT_BRAKE && !result_q.signal_lost)
  // Coast mode drives every bridge input low.
  `MDSR_ASSERT_IMPL(a_coast_pattern, out_valid_q && result_q.drive_mode == MODE_COAST,
                    result_q.bridge_pattern == PAT_COAST)
  // Packets, ticks and the unused kind never create a result.
  `MDSR_ASSERT_NEXT(a_no_spurious, fire && !has_result && (!out_valid_q || m_axis_tready_i),
                    !out_valid_q)

endmodule
`default_nettype wire
